// ===== sv/rgbscl_pkg.sv =====
// Shared types, constants and helpers for the 3-to-5 row RGB565 scaler.
`timescale 1ns / 1ps
package rgbscl_pkg;

    localparam int PixW     = 16;
    localparam int ColW     = 10;
    localparam int BandW    = 9;
    localparam int CoordW   = 11;
    localparam int YBaseW   = 12;
    localparam int Rows     = 5;
    localparam int RowSelW  = 3;
    localparam int InDataW  = 48;
    localparam int OutDataW = 40;
    localparam int AddrW    = 4;
    localparam int ApbW     = 32;

    localparam logic [9:0]  SrcWidthRst   = 10'd160;
    localparam logic [9:0]  SrcHeightRst  = 10'd160;
    localparam logic [10:0] RowLimitRst   = 11'd240;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH   = 2'd0,
        REG_SRC_HEIGHT  = 2'd1,
        REG_ROW_LIMIT   = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [9:0]  src_width;
        logic [9:0]  src_height;
        logic [10:0] row_limit;
    } cfg_t;

    // One column of work: the five candidate pixels and where they go.
    typedef struct packed {
        logic [Rows-1:0][PixW-1:0] px;
        logic [CoordW-1:0]         dest_x;
        logic [YBaseW-1:0]         y_base;
        logic [Rows-1:0]           row_mask;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } q_wr_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_rd_t;

    // Per-channel floor average, no carry between channels.
    function automatic logic [PixW-1:0] avg565(input logic [PixW-1:0] a,
                                               input logic [PixW-1:0] b);
        logic [5:0] r;
        logic [6:0] g;
        logic [5:0] bl;
        r  = {1'b0, a[15:11]} + {1'b0, b[15:11]};
        g  = {1'b0, a[10:5]}  + {1'b0, b[10:5]};
        bl = {1'b0, a[4:0]}   + {1'b0, b[4:0]};
        return {r[5:1], g[6:1], bl[5:1]};
    endfunction

endpackage

// ===== sv/rgbscl_front.sv =====
// Front end: accepts input columns, tracks position, builds jobs with row masks.
`timescale 1ns / 1ps
module rgbscl_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rgbscl_pkg::cfg_t                    cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rgbscl_pkg::InDataW-1:0]      s_tdata,
    input  logic                                q_full,
    output rgbscl_pkg::q_wr_t                   q_wr
);

    logic [rgbscl_pkg::ColW-1:0]   col_reg, col_next;
    logic [rgbscl_pkg::BandW-1:0]  band_reg, band_next;
    logic [rgbscl_pkg::ColW:0]     col_plus;
    logic [rgbscl_pkg::BandW:0]    band_plus;
    logic [rgbscl_pkg::YBaseW-1:0] band_plus3;
    logic [rgbscl_pkg::YBaseW-1:0] y_base;
    logic [rgbscl_pkg::PixW-1:0]   top_px, mid_px, bot_px;
    logic [rgbscl_pkg::Rows-1:0]   mask;
    logic                          accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign top_px = s_tdata[15:0];
    assign mid_px = s_tdata[31:16];
    assign bot_px = s_tdata[47:32];

    // 5 * band as shift and add
    assign y_base = {1'b0, band_reg, 2'b00} + {3'b000, band_reg};

    always_comb begin
        for (int k = 0; k < rgbscl_pkg::Rows; k++) begin
            mask[k] = (y_base + rgbscl_pkg::YBaseW'(k)) < {1'b0, cfg.row_limit};
        end
    end

    always_comb begin
        q_wr.push            = accept && (mask != '0);
        q_wr.job.px[0]       = top_px;
        q_wr.job.px[1]       = rgbscl_pkg::avg565(top_px, mid_px);
        q_wr.job.px[2]       = mid_px;
        q_wr.job.px[3]       = rgbscl_pkg::avg565(mid_px, bot_px);
        q_wr.job.px[4]       = bot_px;
        q_wr.job.dest_x      = {col_reg, 1'b0};
        q_wr.job.y_base      = y_base;
        q_wr.job.row_mask    = mask;
    end

    assign col_plus   = {1'b0, col_reg} + 1'b1;
    assign band_plus  = {1'b0, band_reg} + 1'b1;
    assign band_plus3 = {1'b0, band_plus, 1'b0} + {2'b00, band_plus};

    always_comb begin
        col_next  = col_reg;
        band_next = band_reg;
        if (accept) begin
            if (col_plus >= {1'b0, cfg.src_width}) begin
                col_next = '0;
                if (band_plus3 >= {2'b00, cfg.src_height}) begin
                    band_next = '0;
                end else begin
                    band_next = band_plus[rgbscl_pkg::BandW-1:0];
                end
            end else begin
                col_next = col_plus[rgbscl_pkg::ColW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            band_reg <= '0;
        end else begin
            col_reg  <= col_next;
            band_reg <= band_next;
        end
    end

endmodule

// ===== sv/rgbscl_queue.sv =====
// Two-entry job queue between front and back ends.
`timescale 1ns / 1ps
module rgbscl_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  rgbscl_pkg::q_wr_t  q_wr,
    output logic               q_full,
    output rgbscl_pkg::q_rd_t  q_rd,
    input  logic               q_pop
);

    rgbscl_pkg::job_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_pop;

    assign q_full     = (count_reg == 2'd2);
    assign q_rd.valid = (count_reg != 2'd0);
    assign q_rd.job   = entry_reg[rd_ptr_reg];
    assign do_pop     = q_pop && q_rd.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ q_wr.push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, q_wr.push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (q_wr.push) begin
            entry_reg[wr_ptr_reg] <= q_wr.job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/rgbscl_back.sv =====
// Back end: walks the kept rows of the head job, one result per cycle while the output is not stalled.
`timescale 1ns / 1ps
module rgbscl_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rgbscl_pkg::q_rd_t                   q_rd,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rgbscl_pkg::OutDataW-1:0]     m_tdata,
    output logic                                m_tlast
);

    logic [rgbscl_pkg::Rows-1:0]    rem_reg, rem_next;
    logic                           started_reg, started_next;
    logic                           valid_reg, valid_next;
    logic [rgbscl_pkg::PixW-1:0]    pixel_reg;
    logic [rgbscl_pkg::CoordW-1:0]  x_reg;
    logic [rgbscl_pkg::CoordW-1:0]  y_reg;
    logic                           last_reg;
    logic [rgbscl_pkg::Rows-1:0]    cur_mask;
    logic [rgbscl_pkg::Rows-1:0]    left_mask;
    logic [rgbscl_pkg::RowSelW-1:0] sel;
    logic [rgbscl_pkg::YBaseW-1:0]  y_full;
    logic                           out_free;
    logic                           emit;

    assign cur_mask = started_reg ? rem_reg : q_rd.job.row_mask;

    // lowest kept row first
    always_comb begin
        sel = '0;
        for (int k = rgbscl_pkg::Rows - 1; k >= 0; k--) begin
            if (cur_mask[k]) begin
                sel = rgbscl_pkg::RowSelW'(k);
            end
        end
    end

    always_comb begin
        left_mask      = cur_mask;
        left_mask[sel] = 1'b0;
    end

    assign out_free = !valid_reg || m_tready;
    assign emit     = out_free && q_rd.valid;
    assign q_pop    = emit && (left_mask == '0);
    assign y_full   = q_rd.job.y_base + {{(rgbscl_pkg::YBaseW - rgbscl_pkg::RowSelW){1'b0}}, sel};

    always_comb begin
        rem_next     = rem_reg;
        started_next = started_reg;
        valid_next   = valid_reg;
        if (out_free) begin
            valid_next = q_rd.valid;
        end
        if (emit) begin
            rem_next     = left_mask;
            started_next = (left_mask != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end else begin
            rem_reg     <= rem_next;
            started_reg <= started_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            pixel_reg <= q_rd.job.px[sel];
            x_reg     <= q_rd.job.dest_x;
            y_reg     <= y_full[rgbscl_pkg::CoordW-1:0];
            last_reg  <= (left_mask == '0);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, y_reg, x_reg, pixel_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== sv/rgb565_three_to_five_row_scaler_core.sv =====
// Top level of the RGB565 vertical 3-to-5 row scaler with column doubling.
//
// channel  | dir | handshake          | content
// ---------+-----+--------------------+-----------------------------------------
// s_       | in  | s_tvalid/s_tready  | one column of a 3-row source band
// m_       | out | m_tvalid/m_tready  | one destination pixel with coordinates
// APB      | in  | psel/penable/pready| src_width, src_height, row_limit
//
// The back end gives one result per cycle while m_tready allows, so a column with
// all five rows kept yields five results; its single output register sets that pace.
// A column whose rows are all suppressed is dropped in the front end and never queued.
// A two-job queue lets the front end keep taking columns while results stall.
// Synchronous active-low reset clears counters, queue and output valid;
// registers return to 160/160/240.
`timescale 1ns / 1ps
module rgb565_three_to_five_row_scaler_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] top_pixel, [31:16] middle_pixel, [47:32] bottom_pixel
    input  logic [rgbscl_pkg::InDataW-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] pixel, [26:16] dest_x, [37:27] dest_y, [39:38] zero
    output logic [rgbscl_pkg::OutDataW-1:0]     m_tdata,
    output logic                                m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rgbscl_pkg::AddrW-1:0]        paddr,
    input  logic [rgbscl_pkg::ApbW-1:0]         pwdata,
    output logic [rgbscl_pkg::ApbW-1:0]         prdata,
    output logic                                pready
);

    rgbscl_pkg::cfg_t     cfg_reg, cfg_next;
    rgbscl_pkg::reg_idx_t reg_idx;
    rgbscl_pkg::q_wr_t    q_wr;
    rgbscl_pkg::q_rd_t    q_rd;
    logic                 q_full;
    logic                 q_pop;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = rgbscl_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                rgbscl_pkg::REG_SRC_WIDTH:  cfg_next.src_width  = pwdata[9:0];
                rgbscl_pkg::REG_SRC_HEIGHT: cfg_next.src_height = pwdata[9:0];
                rgbscl_pkg::REG_ROW_LIMIT:  cfg_next.row_limit  = pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rgbscl_pkg::REG_SRC_WIDTH:  prdata = {22'd0, cfg_reg.src_width};
            rgbscl_pkg::REG_SRC_HEIGHT: prdata = {22'd0, cfg_reg.src_height};
            rgbscl_pkg::REG_ROW_LIMIT:  prdata = {21'd0, cfg_reg.row_limit};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_width  <= rgbscl_pkg::SrcWidthRst;
            cfg_reg.src_height <= rgbscl_pkg::SrcHeightRst;
            cfg_reg.row_limit  <= rgbscl_pkg::RowLimitRst;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rgbscl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_wr     (q_wr)
    );

    rgbscl_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_rd    (q_rd),
        .q_pop   (q_pop)
    );

    rgbscl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rd     (q_rd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the RGB565 3-to-5 row scaler: APB setup, stream stimulus, scoreboard.
`timescale 1ns / 1ps
module tb_top;
    import rgbscl_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 20;
    localparam int LongHold    = 300;

    // Tracks the scaler's column/band counters and queues the destination pixels it must emit.
    class scaled_pixel_board;
        typedef struct {
            logic [15:0] pixel;
            logic [10:0] dest_x;
            logic [10:0] dest_y;
            logic        last;
        } dest_pixel_t;

        bit [9:0]    src_width;
        bit [9:0]    src_height;
        bit [10:0]   row_limit;
        bit [9:0]    column;
        bit [8:0]    band;
        dest_pixel_t expected_pixels[$];
        int          errors;
        int          columns_seen;
        int          pixels_checked;
        int          settings_used;

        function new();
            src_width   = SrcWidthRst;
            src_height  = SrcHeightRst;
            row_limit   = RowLimitRst;
            column      = '0;
            band        = '0;
            errors      = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_SRC_WIDTH:  src_width  = value[9:0];
                REG_SRC_HEIGHT: src_height = value[9:0];
                REG_ROW_LIMIT:  row_limit  = value[10:0];
                default: ;
            endcase
        endfunction

        // Floor average per channel, no carry across channel boundaries.
        function logic [15:0] blend(logic [15:0] a, logic [15:0] b);
            int r;
            int g;
            int bl;
            r  = (int'(a[15:11]) + int'(b[15:11])) / 2;
            g  = (int'(a[10:5])  + int'(b[10:5]))  / 2;
            bl = (int'(a[4:0])   + int'(b[4:0]))   / 2;
            return {r[4:0], g[5:0], bl[4:0]};
        endfunction

        function void take_column(logic [15:0] top, logic [15:0] mid, logic [15:0] bot);
            logic [15:0] rows [5];
            dest_pixel_t p;
            int          y_base;
            int          kept;
            int          k;
            rows[0] = top;
            rows[1] = blend(top, mid);
            rows[2] = mid;
            rows[3] = blend(mid, bot);
            rows[4] = bot;
            y_base  = 5 * int'(band);
            kept    = 0;
            columns_seen++;
            for (k = 0; k < 5; k++) begin
                if (y_base + k < int'(row_limit)) begin
                    p.pixel  = rows[k];
                    p.dest_x = {column, 1'b0};
                    p.dest_y = 11'(y_base + k);
                    p.last   = 1'b0;
                    expected_pixels.push_back(p);
                    kept++;
                end
            end
            if (kept > 0) begin
                expected_pixels[expected_pixels.size() - 1].last = 1'b1;
            end
            // advance column, then band; a counter past a shrunken size wraps here
            if (int'(column) + 1 >= int'(src_width)) begin
                column = '0;
                if (3 * (int'(band) + 1) >= int'(src_height)) begin
                    band = '0;
                end else begin
                    band = band + 9'd1;
                end
            end else begin
                column = column + 10'd1;
            end
        endfunction

        function void check_pixel(logic [15:0] pixel, logic [10:0] dest_x, logic [10:0] dest_y,
                                  logic last);
            dest_pixel_t want;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel %h x=%0d y=%0d last=%b",
                         $time, pixel, dest_x, dest_y, last);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            pixels_checked++;
            if ({pixel, dest_x, dest_y, last} !== {want.pixel, want.dest_x, want.dest_y, want.last})
            begin
                $display("%0t: mismatch expected pixel %h x=%0d y=%0d last=%b, got %h x=%0d y=%0d last=%b",
                         $time, want.pixel, want.dest_x, want.dest_y, want.last,
                         pixel, dest_x, dest_y, last);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OutDataW-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [AddrW-1:0]     paddr    = '0;
    logic [ApbW-1:0]      pwdata   = '0;
    logic [ApbW-1:0]      prdata;
    logic                 pready;

    bit                   idle_on      = 1'b1;
    bit                   hold_request = 1'b0;
    int                   cycle_count  = 0;
    scaled_pixel_board    sb = new();

    rgb565_three_to_five_row_scaler_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d pixels still expected",
                     cycle_count, sb.expected_pixels.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // Result side: check every transfer, stall in random bursts, one long hold on request.
    initial begin : result_sink
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sb.check_pixel(m_tdata[15:0], m_tdata[26:16], m_tdata[37:27], m_tlast);
            end
            if (hold_request && !hold_done) begin
                stall_left = LongHold;
                hold_done  = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && aresetn && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bus goes idle between writes
        @(posedge aclk);
        sb.set_reg(idx, value);
    endtask

    // Hold valid across back-to-back transfers; drop it only for an idle burst.
    task automatic send_column(input logic [15:0] top, input logic [15:0] mid,
                               input logic [15:0] bot);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bot, mid, top};
        do @(posedge aclk); while (!s_tready);
        sb.take_column(top, mid, bot);
    endtask

    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        // suppressed columns may still be in flight with nothing expected
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic configure(input int width, input int height, input int rows);
        wait_drained();
        apb_write(REG_SRC_WIDTH, width);
        apb_write(REG_SRC_HEIGHT, height);
        apb_write(REG_ROW_LIMIT, rows);
        sb.settings_used++;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_column(pick_pixel(), pick_pixel(), pick_pixel());
    endtask

    logic [47:0] directed [16] = '{
        48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'hFFFF_0000_FFFF, 48'h0000_FFFF_0000,
        48'hF800_0800_F800, 48'h07E0_0020_07E0, 48'h001F_0001_001F, 48'h0821_0000_0821,
        48'h07E0_F81F_07E0, 48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555, 48'h0001_FFFE_0001,
        48'hF7DE_0821_F7DE, 48'h8410_7BEF_8410, 48'h1234_5678_9ABC, 48'hFFFF_0000_0000
    };

    initial begin : stimulus
        int i;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings first, then a tiny frame that wraps and clips rows
        for (i = 0; i < 8; i++) begin
            send_column(directed[i][15:0], directed[i][31:16], directed[i][47:32]);
        end
        configure(4, 6, 8);
        for (i = 8; i < 16; i++) begin
            send_column(directed[i][15:0], directed[i][31:16], directed[i][47:32]);
        end

        configure(3, 10, 12);
        run_random(40);
        configure(0, 0, 0);
        run_random(8);
        configure(1, 1023, 2047);
        hold_request <= 1'b1;
        run_random(110);
        configure(10, 60, 2047);
        run_random(34);
        // shrink both sizes below the live counters
        configure(3, 3, 7);
        run_random(25);
        configure(1023, 1, 1);
        run_random(25);
        configure($urandom_range(1, 12), $urandom_range(1, 40), $urandom_range(1, 60));
        run_random(40);
        idle_on <= 1'b0;
        configure(7, 20, 33);
        run_random(30);

        wait_drained();
        $display("%0d columns sent over %0d size settings, %0d pixels checked, %0d errors",
                 sb.columns_seen, sb.settings_used, sb.pixels_checked, sb.errors);
        if (sb.expected_pixels.size() != 0) begin
            $display("%0d expected pixels never arrived", sb.expected_pixels.size());
        end
        if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
